>>> src/ecd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared types and codes of the Elias code bit decoder: code kinds, decoder
// phases and the control-state record passed between the top and step logic.
// ----------------------------------------------------------------------------
package ecd_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int IN_DATA_W      = 8;
    localparam int OUT_DATA_W     = 32;
    localparam int COUNT_W        = 32;

    // code_kind register values
    localparam logic [1:0] KIND_UNARY = 2'd0;
    localparam logic [1:0] KIND_GAMMA = 2'd1;
    localparam logic [1:0] KIND_DELTA = 2'd2;
    localparam logic [1:0] KIND_OMEGA = 2'd3;

    // decoder phases
    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_GAMMA  = 2'd1;
    localparam logic [1:0] PH_DELTA  = 2'd2;
    localparam logic [1:0] PH_OMEGA  = 2'd3;

    typedef logic [1:0] t_phase;
    typedef logic [1:0] t_kind;

    typedef struct packed {
        t_phase               phase;
        logic [COUNT_W-1:0]   zero_count;
        logic [COUNT_W-1:0]   bits_left;
        logic                 ovf;
    } t_ctl;

    localparam t_ctl CTL_START = '{phase: PH_PREFIX, zero_count: '0,
                                   bits_left: '0, ovf: 1'b0};

endpackage

>>> src/ecd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_step
// One decoder step: next control state, next value accumulator and the
// result of a finished codeword for a single stream bit.
// ----------------------------------------------------------------------------
module ecd_step #(
    parameter int VALUE_BITS = ecd_pkg::VALUE_BITS_DEF
) (
    input  ecd_pkg::t_kind             i_kind,
    input  logic                       i_bit,
    input  ecd_pkg::t_ctl              i_ctl,
    input  logic [VALUE_BITS-1:0]      i_acc,
    output ecd_pkg::t_ctl              o_ctl,
    output logic [VALUE_BITS-1:0]      o_acc,
    output logic                       o_emit,
    output logic [ecd_pkg::OUT_DATA_W-1:0] o_value,
    output logic                       o_ovf
);
    import ecd_pkg::*;

    localparam logic [VALUE_BITS-1:0] ACC_ONE = VALUE_BITS'(1);

    logic [VALUE_BITS-1:0] w_shift;
    logic                  w_shift_ovf;
    logic [COUNT_W-1:0]    w_left_dec;
    logic [VALUE_BITS-1:0] w_len1;
    logic [63:0]           w_len1_64;
    logic [63:0]           w_acc_64;
    logic [COUNT_W-1:0]    w_len1_sat;
    logic [COUNT_W-1:0]    w_acc_sat;
    logic [VALUE_BITS-1:0] w_inc;

    assign w_shift     = {i_acc[VALUE_BITS-2:0], i_bit};
    assign w_shift_ovf = i_ctl.ovf | i_acc[VALUE_BITS-1];
    assign w_left_dec  = i_ctl.bits_left - COUNT_W'(1);
    assign w_len1      = w_shift - ACC_ONE;
    assign w_len1_64   = 64'(w_len1);
    assign w_acc_64    = 64'(i_acc);
    // saturate group lengths to 32 bits
    assign w_len1_sat  = (|w_len1_64[63:32]) ? '1 : w_len1_64[31:0];
    assign w_acc_sat   = (|w_acc_64[63:32]) ? '1 : w_acc_64[31:0];
    assign w_inc       = i_acc + ACC_ONE;

    always_comb begin
        o_ctl   = i_ctl;
        o_acc   = i_acc;
        o_emit  = 1'b0;
        o_value = 32'(64'(i_acc));
        o_ovf   = i_ctl.ovf;
        case (i_ctl.phase)
            PH_GAMMA, PH_DELTA, PH_OMEGA: begin
                // shift one bit into the group, count it off
                o_acc           = w_shift;
                o_ctl.ovf       = w_shift_ovf;
                o_ctl.bits_left = w_left_dec;
                o_value         = 32'(64'(w_shift));
                o_ovf           = w_shift_ovf;
                if (w_left_dec == '0) begin
                    if (i_ctl.phase == PH_GAMMA && i_kind == KIND_DELTA &&
                        w_len1 != '0) begin
                        o_ctl.bits_left = w_len1_sat;
                        o_ctl.phase     = PH_DELTA;
                        o_acc           = ACC_ONE;
                    end else if (i_ctl.phase == PH_OMEGA) begin
                        o_ctl.phase = PH_PREFIX;
                    end else begin
                        o_emit = 1'b1;
                    end
                end
            end
            default: begin
                case (i_kind)
                    KIND_UNARY: begin
                        if (i_bit) begin
                            o_emit = 1'b1;
                        end else begin
                            o_acc = w_inc;
                            if (w_inc == '0) begin
                                o_ctl.ovf = 1'b1;
                            end
                        end
                    end
                    KIND_OMEGA: begin
                        if (!i_bit) begin
                            o_emit = 1'b1;
                        end else begin
                            // current value is the length of the next group
                            o_ctl.bits_left = w_acc_sat;
                            o_acc           = ACC_ONE;
                            o_ctl.phase     = PH_PREFIX;
                            if (w_acc_sat != '0) begin
                                o_ctl.phase = PH_OMEGA;
                            end
                        end
                    end
                    default: begin
                        if (!i_bit) begin
                            if (i_ctl.zero_count != '1) begin
                                o_ctl.zero_count = i_ctl.zero_count + COUNT_W'(1);
                            end
                        end else if (i_ctl.zero_count == '0) begin
                            o_emit = 1'b1;
                        end else begin
                            o_ctl.bits_left = i_ctl.zero_count;
                            o_acc           = ACC_ONE;
                            o_ctl.phase     = PH_GAMMA;
                        end
                    end
                endcase
            end
        endcase
        // a finished codeword restarts the decoder
        if (o_emit) begin
            o_ctl = CTL_START;
            o_acc = ACC_ONE;
        end
    end

endmodule

>>> src/elias_code_bit_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elias_code_bit_decoder
// Bit-serial decoder for unary, Elias gamma, delta and omega codes.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the coded stream one bit per item on the s_axis side, bit in
//   tdata[0]. Each time a codeword ends, one item leaves on m_axis: the
//   decoded value in tdata (low 32 bits of a VALUE_BITS-wide value) and the
//   overflow flag in tuser, set when the value or any intermediate length
//   of the codeword needed more than VALUE_BITS bits.
//   Write the code kind through i_cfg_we / i_cfg_wdata while the stream is
//   idle: 0 unary, 1 gamma, 2 delta, 3 omega. A write drops any partial
//   codeword and restarts decoding.
//   An accepted bit is held in the input register, then the step logic
//   updates the decoder state and loads the result register, so a result is
//   offered from the result register after the bit that ends its codeword.
//   Throughput is one bit per cycle while the receiver does not stall.
//   A stalled receiver holds the result register; the input register still
//   takes a bit, and further bits wait only while both registers are full.
//   Reset empties both registers, selects gamma and starts a new codeword.
// ----------------------------------------------------------------------------
module elias_code_bit_decoder #(
    parameter int VALUE_BITS = ecd_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: code_kind
    input  logic                              i_cfg_we,
    input  ecd_pkg::t_kind                    i_cfg_wdata,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [ecd_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,  // [0] code_bit
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [ecd_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,  // [31:0] decoded_value
    output logic [0:0]                        o_m_axis_tuser   // [0] overflow
);
    import ecd_pkg::*;

    localparam logic [VALUE_BITS-1:0] ACC_ONE = VALUE_BITS'(1);

    // code kind register
    t_kind                 r_kind;

    // input register
    logic                  r_in_valid;
    logic                  r_in_bit;

    // decoder state
    t_ctl                  r_ctl;
    logic [VALUE_BITS-1:0] r_acc;

    // result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_value;
    logic                  r_out_ovf;

    // step outputs
    t_ctl                  n_ctl;
    logic [VALUE_BITS-1:0] n_acc;
    logic                  w_emit;
    logic [OUT_DATA_W-1:0] w_value;
    logic                  w_ovf;

    logic                  w_advance;
    logic                  w_in_take;

    // process the held bit when the result register can take a result
    assign w_advance       = r_in_valid & (~r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~r_in_valid | w_advance;
    assign w_in_take       = i_s_axis_tvalid & o_s_axis_tready;

    ecd_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .i_kind  (r_kind),
        .i_bit   (r_in_bit),
        .i_ctl   (r_ctl),
        .i_acc   (r_acc),
        .o_ctl   (n_ctl),
        .o_acc   (n_acc),
        .o_emit  (w_emit),
        .o_value (w_value),
        .o_ovf   (w_ovf)
    );

    // code kind; a write restarts the codeword below
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_GAMMA;
        end else if (i_cfg_we) begin
            r_kind <= i_cfg_wdata;
        end
    end

    // input register: hold the bit until the step consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_bit <= i_s_axis_tdata[0];
        end
    end

    // decoder state: advance one bit per step, drop everything on a config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_ctl <= CTL_START;
            r_acc <= ACC_ONE;
        end else if (w_advance) begin
            r_ctl <= n_ctl;
            r_acc <= n_acc;
        end
    end

    // result register: load on a finished codeword, clear once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out_value <= w_value;
            r_out_ovf   <= w_ovf;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_value;
    assign o_m_axis_tuser[0] = r_out_ovf;

    // a finished codeword leaves the decoder at the start of a new one
    a_emit_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_emit && !i_cfg_we) |=>
            (r_ctl.phase == PH_PREFIX && r_ctl.zero_count == '0 &&
             r_acc == ACC_ONE && !r_ctl.ovf))
        else $error("decoder state not restarted after a codeword");

    // a group phase always has bits still to read
    a_group_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.phase != PH_PREFIX) |-> (r_ctl.bits_left != '0))
        else $error("group phase with no bits left");

    // delta and omega groups only arise under their own code kind
    a_phase_kind : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_ctl.phase == PH_DELTA) |-> (r_kind == KIND_DELTA)) and
        ((r_ctl.phase == PH_OMEGA) |-> (r_kind == KIND_OMEGA)))
        else $error("decoder phase does not match the code kind");

    // a configuration write selects the new code and restarts decoding
    a_cfg_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_kind == $past(i_cfg_wdata) && r_ctl.phase == PH_PREFIX &&
                      r_acc == ACC_ONE))
        else $error("configuration write did not restart the decoder");

    // a result waiting on a stalled receiver is never overwritten
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !w_advance)
        else $error("result register overwritten while stalled");

endmodule
